// ===== sv/gpa_pkg.sv =====
// Package with shared types, constants and codes of the guarded page allocator.
`timescale 1ns / 1ps
package gpa_pkg;
    localparam int NUM_PAGES = 1024;
    localparam int PW = $clog2(NUM_PAGES);
    localparam int CW = PW + 1;

    typedef logic [PW-1:0] t_page;
    typedef logic [CW-1:0] t_cnt;

    localparam logic [1:0] CMD_INIT  = 2'd0;
    localparam logic [1:0] CMD_ALLOC = 2'd1;
    localparam logic [1:0] CMD_FREE  = 2'd2;
    localparam logic [1:0] CMD_QUERY = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NONE    = 2'd1;
    localparam logic [1:0] ST_BADPAGE = 2'd2;
    localparam logic [1:0] ST_RANGE   = 2'd3;
endpackage

// ===== sv/gpa_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module gpa_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/guarded_page_allocator_unit.sv =====
// Top level of the guarded page allocator: command sequencer around three RAMs.
`timescale 1ns / 1ps
// Usage: a command (i_cmd, i_page, i_index) is transferred at a rising edge with
// start high and busy low. The block then runs a small sequencer and, when done,
// shows exactly one result on o_result_page / o_status for one cycle, marked by
// o_done. The receiver cannot stall; the result is taken in that cycle.
// The first_page register is written over its own channel (i_cfg_valid, o_cfg_ready);
// it is ready whenever the block is idle.
// Sequencing: init sweeps every page, whatever first_page is, clearing its held bit and
// pushing it on the free stack when it is at or above first_page, then shows the result
// and returns to idle. Alloc walks the free stack from the top, for each entry reading
// the entry and then both neighbor held bits, and then shifts the tail down one entry
// at a time (read, then write). Free compacts the allocated list one entry at a time
// (read, then write). Query reads the list entry, then shows the result.
// Reset clears counts, first_page and the sequencer, then runs a clearing pass over
// every page of the held-bit RAM with busy high, so every page reads as not
// allocated before the first command. List RAM contents are undefined until written
// and are never read beyond the counts.
module guarded_page_allocator_unit
    import gpa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_cmd,
    input  logic [9:0] i_page,
    input  logic [9:0] i_index,
    output logic       o_done,
    output logic [9:0] o_result_page,
    output logic [1:0] o_status,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [9:0] i_cfg_first_page
);
    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_INIT  = 13'b0000000000010,
        S_ARD   = 13'b0000000000100,
        S_ALO   = 13'b0000000001000,
        S_AHI   = 13'b0000000010000,
        S_ACHK  = 13'b0000000100000,
        S_SHRD  = 13'b0000001000000,
        S_SHWR  = 13'b0000010000000,
        S_FRD   = 13'b0000100000000,
        S_FWR   = 13'b0001000000000,
        S_QRD   = 13'b0010000000000,
        S_OUT   = 13'b0100000000000,
        S_CLR   = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;
    t_page  r_first, r_page, n_page, r_res, n_res;
    logic [1:0] r_cmd, r_st, n_st;
    t_cnt   r_ftot, n_ftot, r_ttot, n_ttot;
    t_cnt   r_k, n_k, r_w, n_w;
    t_page  r_idx;
    logic   r_nb, n_nb;

    // Free stack RAM.
    logic  fs_we;   t_page fs_wa, fs_wd, fs_ra, fs_rd;
    // Allocated list RAM.
    logic  tl_we;   t_page tl_wa, tl_wd, tl_ra, tl_rd;
    // Held-count RAM (one bit per page: any allocated copy).
    logic  hd_we;   t_page hd_wa, hd_ra;
    logic  hd_wd, hd_rd;

    gpa_ram #(.WIDTH(PW), .DEPTH(NUM_PAGES)) u_fs (
        .i_clk, .i_we(fs_we), .i_waddr(fs_wa), .i_wdata(fs_wd),
        .i_raddr(fs_ra), .o_rdata(fs_rd));
    gpa_ram #(.WIDTH(PW), .DEPTH(NUM_PAGES)) u_tl (
        .i_clk, .i_we(tl_we), .i_waddr(tl_wa), .i_wdata(tl_wd),
        .i_raddr(tl_ra), .o_rdata(tl_rd));
    gpa_ram #(.WIDTH(1), .DEPTH(NUM_PAGES)) u_hd (
        .i_clk, .i_we(hd_we), .i_waddr(hd_wa), .i_wdata(hd_wd),
        .i_raddr(hd_ra), .o_rdata(hd_rd));

    localparam t_cnt NP = t_cnt'(NUM_PAGES);
    localparam t_page PMAX = t_page'(NUM_PAGES - 1);

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state; n_page = r_page; n_res = r_res; n_st = r_st;
        n_ftot = r_ftot; n_ttot = r_ttot; n_k = r_k; n_w = r_w; n_nb = r_nb;
        fs_we = 1'b0; fs_wa = '0; fs_wd = '0; fs_ra = r_k[PW-1:0];
        tl_we = 1'b0; tl_wa = '0; tl_wd = '0; tl_ra = r_k[PW-1:0];
        hd_we = 1'b0; hd_wa = '0; hd_wd = 1'b0; hd_ra = '0;
        unique case (r_state)
            S_CLR: begin
                // After reset every held bit is cleared once.
                hd_we = 1'b1; hd_wa = r_k[PW-1:0];
                n_k = r_k + 1'b1;
                if (r_k[PW-1:0] == PMAX) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    n_res = '0; n_st = ST_OK; n_k = '0; n_w = '0;
                    n_page = i_page;
                    unique case (i_cmd)
                        CMD_INIT: begin
                            n_ftot = '0; n_ttot = '0;
                            n_state = S_INIT;
                        end
                        CMD_ALLOC: begin
                            n_k = r_ftot;
                            if (r_ttot >= NP || r_ftot == '0) begin
                                n_st = ST_NONE; n_state = S_OUT;
                            end else begin
                                n_state = S_ARD;
                            end
                        end
                        CMD_FREE: begin
                            if (i_page < r_first) begin
                                n_st = ST_BADPAGE; n_state = S_OUT;
                            end else if (r_ftot >= NP) begin
                                n_st = ST_RANGE; n_state = S_OUT;
                            end else begin
                                n_state = S_FRD;
                            end
                        end
                        default: begin
                            if (t_cnt'(i_index) >= r_ttot) begin
                                n_st = ST_RANGE; n_state = S_OUT;
                            end else begin
                                n_state = S_QRD;
                            end
                        end
                    endcase
                end
            end
            S_INIT: begin
                // r_k sweeps every page: clear held bit, push pages >= first.
                hd_we = 1'b1; hd_wa = r_k[PW-1:0];
                if (r_k[PW-1:0] >= r_first) begin
                    fs_we = 1'b1; fs_wa = r_ftot[PW-1:0]; fs_wd = r_k[PW-1:0];
                    n_ftot = r_ftot + 1'b1;
                end
                n_k = r_k + 1'b1;
                if (r_k[PW-1:0] == PMAX) n_state = S_OUT;
            end
            S_ARD: begin
                fs_ra = PW'(r_k - 1'b1);
                n_state = S_ALO;
            end
            S_ALO: begin
                n_page = fs_rd;
                hd_ra = fs_rd - 1'b1;
                n_state = S_AHI;
            end
            S_AHI: begin
                hd_ra = r_page + 1'b1;
                n_nb = (r_page != '0) && hd_rd;
                n_state = S_ACHK;
            end
            S_ACHK: begin
                if (r_nb || (r_page != PMAX && hd_rd)) begin
                    n_k = r_k - 1'b1;
                    if (r_k == t_cnt'(1)) begin
                        n_st = ST_NONE; n_state = S_OUT;
                    end else begin
                        n_state = S_ARD;
                    end
                end else begin
                    tl_we = 1'b1; tl_wa = r_ttot[PW-1:0]; tl_wd = r_page;
                    n_ttot = r_ttot + 1'b1;
                    hd_we = 1'b1; hd_wa = r_page; hd_wd = 1'b1;
                    n_res = r_page;
                    n_state = S_SHRD;
                end
            end
            S_SHRD: begin
                // r_k - 1 is the hole; move entry r_k down.
                if (r_k >= r_ftot) begin
                    n_ftot = r_ftot - 1'b1; n_state = S_OUT;
                end else begin
                    fs_ra = r_k[PW-1:0];
                    n_state = S_SHWR;
                end
            end
            S_SHWR: begin
                fs_we = 1'b1; fs_wa = PW'(r_k - 1'b1); fs_wd = fs_rd;
                n_k = r_k + 1'b1;
                n_state = S_SHRD;
            end
            S_FRD: begin
                if (r_k >= r_ttot) begin
                    fs_we = 1'b1; fs_wa = r_ftot[PW-1:0]; fs_wd = r_page;
                    n_ftot = r_ftot + 1'b1;
                    n_ttot = r_w;
                    hd_we = 1'b1; hd_wa = r_page;
                    n_state = S_OUT;
                end else begin
                    tl_ra = r_k[PW-1:0];
                    n_state = S_FWR;
                end
            end
            S_FWR: begin
                if (tl_rd != r_page) begin
                    tl_we = 1'b1; tl_wa = r_w[PW-1:0]; tl_wd = tl_rd;
                    n_w = r_w + 1'b1;
                end
                n_k = r_k + 1'b1;
                n_state = S_FRD;
            end
            S_QRD: begin
                tl_ra = PW'(r_ttot - 1'b1 - t_cnt'(r_idx));
                n_state = S_OUT;
                n_res = '0;
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    logic r_qv;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR; r_first <= '0; r_ftot <= '0; r_ttot <= '0;
            r_qv <= 1'b0; r_k <= '0;
        end else begin
            r_state <= n_state; r_ftot <= n_ftot; r_ttot <= n_ttot;
            r_k <= n_k;
            r_qv <= (r_state == S_QRD);
            if (i_cfg_valid && o_cfg_ready) r_first <= i_cfg_first_page;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res; r_st <= n_st; r_w <= n_w; r_nb <= n_nb;
        r_page <= n_page;
        if (r_state == S_IDLE && start) begin
            r_cmd <= i_cmd; r_idx <= i_index;
        end
    end

    assign o_done        = (r_state == S_OUT);
    assign o_result_page = r_qv ? tl_rd : r_res;
    assign o_status      = r_st;

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("back-to-back results");
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ftot <= NP) else $error("free count overflow");
    a_taken_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ttot <= NP) else $error("allocated count overflow");
    a_init_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && r_cmd == CMD_INIT) |-> (o_status == ST_OK && r_ttot == '0))
        else $error("init result wrong");
endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for guarded_page_allocator_unit: directed table, then random phases.
`timescale 1ns / 1ps
module tb_top;
    import gpa_pkg::*;

    // Clock, reset and all ports of the block. Every input starts at a known value.
    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic [1:0] i_cmd = CMD_QUERY;
    logic [9:0] i_page = '0;
    logic [9:0] i_index = '0;
    logic       o_done;
    logic [9:0] o_result_page;
    logic [1:0] o_status;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [9:0] i_cfg_first_page = '0;

    guarded_page_allocator_unit DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cmd            (i_cmd),
        .i_page           (i_page),
        .i_index          (i_index),
        .o_done           (o_done),
        .o_result_page    (o_result_page),
        .o_status         (o_status),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_first_page (i_cfg_first_page)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Even if every command were an allocation over a full free list, the run would need
    // well under a third of this.
    initial begin
        #200_000_000;
        $display("guarded_page_allocator_unit verification failed");
        $finish;
    end

    // Shadow copy of the allocator state. The held counts mirror the allocated list and
    // make the neighbor check cheap, just as in the block.
    t_page free_stk [NUM_PAGES];
    int    free_cnt;
    t_page taken_lst [NUM_PAGES];
    int    taken_cnt;
    int    held_cnt [NUM_PAGES];
    t_page first_pg;

    typedef struct packed {
        t_page      page;
        logic [1:0] status;
    } t_alloc_result;

    t_alloc_result pending_results [$];
    int            fail_count;
    int            result_count;
    int            cmd_seen [4];
    int            status_seen [4];

    // Applies one command to the shadow state and returns the result it must produce.
    function automatic t_alloc_result model_command(logic [1:0] cmd, t_page pg, t_page idx);
        t_alloc_result r;
        int            k;
        int            p;
        int            w;
        bit            near;
        r.page   = '0;
        r.status = ST_OK;
        case (cmd)
            CMD_INIT: begin
                free_cnt = 0;
                for (p = first_pg; p < NUM_PAGES; p++) begin
                    free_stk[free_cnt] = t_page'(p);
                    free_cnt++;
                end
                taken_cnt = 0;
                for (p = 0; p < NUM_PAGES; p++) held_cnt[p] = 0;
            end
            CMD_ALLOC: begin
                r.status = ST_NONE;
                if (taken_cnt < NUM_PAGES) begin
                    for (k = free_cnt; k > 0; k--) begin
                        p = free_stk[k-1];
                        near = (p > 0 && held_cnt[p-1] != 0) ||
                               (p < NUM_PAGES - 1 && held_cnt[p+1] != 0);
                        if (!near) begin
                            // Unlink the entry and close the gap above it.
                            for (w = k - 1; w + 1 < free_cnt; w++)
                                free_stk[w] = free_stk[w+1];
                            free_cnt--;
                            taken_lst[taken_cnt] = t_page'(p);
                            taken_cnt++;
                            held_cnt[p]++;
                            r.page   = t_page'(p);
                            r.status = ST_OK;
                            break;
                        end
                    end
                end
            end
            CMD_FREE: begin
                if (pg < first_pg) begin
                    r.status = ST_BADPAGE;
                end else if (free_cnt >= NUM_PAGES) begin
                    r.status = ST_RANGE;
                end else begin
                    free_stk[free_cnt] = pg;
                    free_cnt++;
                    // Every copy of the page leaves the allocated list.
                    w = 0;
                    for (k = 0; k < taken_cnt; k++) begin
                        if (taken_lst[k] != pg) begin
                            taken_lst[w] = taken_lst[k];
                            w++;
                        end
                    end
                    taken_cnt = w;
                    held_cnt[pg] = 0;
                end
            end
            default: begin
                if (idx >= taken_cnt) r.status = ST_RANGE;
                else r.page = taken_lst[taken_cnt - 1 - idx];
            end
        endcase
        return r;
    endfunction

    // Result checker. A result is valid for one cycle only and cannot be held off.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $error("result with no command outstanding: page %0d status %0d",
                       o_result_page, o_status);
                fail_count++;
            end else begin
                t_alloc_result exp_r;
                exp_r = pending_results.pop_front();
                result_count++;
                status_seen[o_status]++;
                if (o_result_page !== exp_r.page) begin
                    $error("result_page: expected %0d, actual %0d", exp_r.page, o_result_page);
                    fail_count++;
                end
                if (o_status !== exp_r.status) begin
                    $error("status: expected %0d, actual %0d", exp_r.status, o_status);
                    fail_count++;
                end
            end
        end
    end

    // Issues one command. Inputs move at the falling edge; since busy only changes at a
    // rising edge, seeing it low here means the transfer happens at the next rising edge.
    // When must_check is set the typed-in result is compared with the predicted one too.
    task automatic issue_command(logic [1:0] cmd, t_page pg, t_page idx,
                                 bit must_check, t_alloc_result typed);
        t_alloc_result r;
        @(negedge i_clk);
        start   = 1'b1;
        i_cmd   = cmd;
        i_page  = pg;
        i_index = idx;
        while (busy) @(negedge i_clk);
        r = model_command(cmd, pg, idx);
        if (must_check && r !== typed) begin
            $error("table row disagrees with prediction: expected %0d/%0d, predicted %0d/%0d",
                   typed.page, typed.status, r.page, r.status);
            fail_count++;
        end
        pending_results.push_back(must_check ? typed : r);
        cmd_seen[cmd]++;
        @(posedge i_clk);
    endtask

    // Lowers start at the next falling edge and keeps it low for the number of cycles passed in.
    task automatic idle_sender(int cycles);
        @(negedge i_clk);
        start = 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    // Waits until every result has come back; the block is idle after each result.
    task automatic drain_results();
        int guard;
        guard = 0;
        @(negedge i_clk);
        start = 1'b0;
        while (pending_results.size() != 0 && guard < 2_000_000) begin
            @(negedge i_clk);
            guard++;
        end
        if (pending_results.size() != 0) begin
            $display("guarded_page_allocator_unit verification failed");
            $finish;
        end else begin
            repeat (4) @(negedge i_clk);
        end
    endtask

    // Writes first_page once the block is idle.
    task automatic write_first_page(t_page value);
        drain_results();
        i_cfg_valid      = 1'b1;
        i_cfg_first_page = value;
        while (!o_cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
        first_pg = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Directed table. A row is either a register write or a command; the typed result is
    // used where it is obvious, otherwise the predictor supplies it.
    typedef struct {
        bit         is_cfg;
        logic [1:0] cmd;
        t_page      page;
        t_page      idx;
        bit         typed;
        t_page      r_page;
        logic [1:0] r_status;
    } t_table_row;

    t_table_row directed_rows [] = '{
        // Before any init the lists are empty.
        '{0, CMD_ALLOC, 10'd0,    10'd0,    1, 10'd0,    ST_NONE},
        '{0, CMD_QUERY, 10'd0,    10'd0,    1, 10'd0,    ST_RANGE},
        '{0, CMD_QUERY, 10'd0,    10'd1023, 1, 10'd0,    ST_RANGE},
        // Full range: the highest page comes first, its neighbor is then skipped.
        '{0, CMD_INIT,  10'd0,    10'd0,    1, 10'd0,    ST_OK},
        '{0, CMD_ALLOC, 10'd0,    10'd0,    1, 10'd1023, ST_OK},
        '{0, CMD_ALLOC, 10'd0,    10'd0,    1, 10'd1021, ST_OK},
        '{0, CMD_QUERY, 10'd0,    10'd0,    1, 10'd1021, ST_OK},
        '{0, CMD_FREE,  10'd1023, 10'd0,    1, 10'd0,    ST_OK},
        '{0, CMD_FREE,  10'd0,    10'd0,    1, 10'd0,    ST_OK},
        '{0, CMD_ALLOC, 10'd0,    10'd0,    0, 10'd0,    ST_OK},
        '{0, CMD_QUERY, 10'd0,    10'd1023, 1, 10'd0,    ST_RANGE},
        // A push onto a full free list is refused.
        '{0, CMD_INIT,  10'd0,    10'd0,    1, 10'd0,    ST_OK},
        '{0, CMD_FREE,  10'd5,    10'd0,    1, 10'd0,    ST_RANGE},
        // Top page only: bad frees, a double free and duplicate allocations.
        '{1, CMD_INIT,  10'd1023, 10'd0,    0, 10'd0,    ST_OK},
        '{0, CMD_INIT,  10'd0,    10'd0,    1, 10'd0,    ST_OK},
        '{0, CMD_FREE,  10'd0,    10'd0,    1, 10'd0,    ST_BADPAGE},
        '{0, CMD_FREE,  10'd1023, 10'd0,    1, 10'd0,    ST_OK},
        '{0, CMD_ALLOC, 10'd0,    10'd0,    1, 10'd1023, ST_OK},
        '{0, CMD_ALLOC, 10'd0,    10'd0,    1, 10'd1023, ST_OK},
        '{0, CMD_QUERY, 10'd0,    10'd1,    1, 10'd1023, ST_OK},
        '{0, CMD_FREE,  10'd1023, 10'd0,    1, 10'd0,    ST_OK},
        '{0, CMD_ALLOC, 10'd0,    10'd0,    0, 10'd0,    ST_OK},
        '{1, CMD_INIT,  10'd1000, 10'd0,    0, 10'd0,    ST_OK},
        '{0, CMD_INIT,  10'd0,    10'd0,    0, 10'd0,    ST_OK},
        '{0, CMD_ALLOC, 10'd0,    10'd0,    0, 10'd0,    ST_OK},
        '{0, CMD_FREE,  10'd999,  10'd0,    1, 10'd0,    ST_BADPAGE}
    };

    initial begin
        int            sent;
        int            phase;
        int            burst;
        int            roll;
        int            settle;
        logic [1:0]    cmd;
        t_page         pg;
        t_page         idx;
        t_page         fp;
        t_alloc_result typed;

        free_cnt   = 0;
        taken_cnt  = 0;
        first_pg   = '0;
        fail_count = 0;
        result_count = 0;
        sent  = 0;
        phase = 0;
        foreach (cmd_seen[c]) cmd_seen[c] = 0;
        foreach (status_seen[c]) status_seen[c] = 0;
        for (int p = 0; p < NUM_PAGES; p++) held_cnt[p] = 0;

        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[n]) begin
            if (directed_rows[n].is_cfg) begin
                write_first_page(directed_rows[n].page);
            end else begin
                typed.page   = directed_rows[n].r_page;
                typed.status = directed_rows[n].r_status;
                issue_command(directed_rows[n].cmd, directed_rows[n].page,
                              directed_rows[n].idx, directed_rows[n].typed, typed);
                sent++;
            end
        end

        // Random phases. Each sets first_page, starts with an init and then runs a mix
        // dominated by allocations and frees of pages that are really allocated. Most
        // phases keep first_page high so that free lists stay short and runs stay fast.
        while (sent < 580) begin
            roll = $urandom_range(0, 9);
            case (roll)
                0: fp = 10'd0;
                1: fp = 10'd1023;
                2: fp = t_page'($urandom_range(0, 1023));
                default: fp = t_page'($urandom_range(900, 1020));
            endcase
            write_first_page(fp);
            issue_command(CMD_INIT, t_page'($urandom), t_page'($urandom), 1'b0, typed);
            sent++;
            burst = $urandom_range(1, 8);
            for (int n = 0; n < 40 && sent < 580; n++) begin
                roll = $urandom_range(0, 99);
                pg   = t_page'($urandom);
                idx  = t_page'($urandom);
                if (roll < 40) begin
                    cmd = CMD_ALLOC;
                end else if (roll < 70) begin
                    cmd  = CMD_FREE;
                    roll = $urandom_range(0, 9);
                    if (roll < 6 && taken_cnt > 0)
                        pg = taken_lst[$urandom_range(0, taken_cnt - 1)];
                    else if (roll < 8)
                        pg = t_page'($urandom_range(first_pg, 1023));
                end else if (roll < 97) begin
                    cmd = CMD_QUERY;
                    if ($urandom_range(0, 9) < 7 && taken_cnt > 0)
                        idx = t_page'($urandom_range(0, taken_cnt - 1));
                end else begin
                    cmd = CMD_INIT;
                end
                issue_command(cmd, pg, idx, 1'b0, typed);
                sent++;
                // Sender bursts: after a burst, drop start for a random gap.
                burst--;
                if (burst == 0) begin
                    burst = $urandom_range(1, 8);
                    if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(0, 6));
                end
            end
            phase++;
        end

        drain_results();
        settle = 0;
        while (settle < 20) begin
            @(negedge i_clk);
            settle++;
        end

        $display("Run covered %0d commands over %0d random phases: init %0d, alloc %0d, free %0d, query %0d.",
                 sent, phase, cmd_seen[CMD_INIT], cmd_seen[CMD_ALLOC],
                 cmd_seen[CMD_FREE], cmd_seen[CMD_QUERY]);
        $display("Results checked %0d: ok %0d, none %0d, bad page %0d, range %0d; mismatches %0d.",
                 result_count, status_seen[ST_OK], status_seen[ST_NONE],
                 status_seen[ST_BADPAGE], status_seen[ST_RANGE], fail_count);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("guarded_page_allocator_unit verification clean");
        end else begin
            $display("guarded_page_allocator_unit verification failed");
        end
        $finish;
    end
endmodule

// ===== guarded_page_allocator_unit.f =====
sv/gpa_pkg.sv
sv/gpa_ram.sv
sv/guarded_page_allocator_unit.sv
tb/tb_top.sv
